// ----- hw/rtl/ilff_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ilff_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 8;
	localparam int ALIGN_BYTES  = 16;

	localparam int REQ_W = 13;
	localparam int OFS_W = 12;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NOFIT  = 2'd1;
	localparam logic [1:0] STATUS_BADPTR = 2'd2;

	typedef struct packed {
		logic             op;
		logic [REQ_W-1:0] request_bytes;
		logic [OFS_W-1:0] user_offset;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [OFS_W-1:0] granted_offset;
	} rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/implicit_list_first_fit_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// First-fit heap allocator over an implicit block list. Block headers live in a
// one-read, one-write memory with one entry per 16-byte unit of the heap; only
// entries at block starts are meaningful. After reset the block first writes the
// initial header (one free block spanning the heap); cmd_stall stays high
// meanwhile. An allocate visits one header per cycle through the memory read port
// and, when the block is split, then writes the header of the free remainder;
// a free walks the same way and, when the pointer is found, reads the following
// header in the last walk step and then does the coalescing write. With a
// 4096-byte heap at most 256 headers are visited. A finished response sits in an
// output register and the next command is taken while it waits; if that response
// is still stalled when the next one is ready, the block holds in its response
// state for as long as the stall lasts.
module implicit_list_first_fit_allocator (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_stall,
	input  wire ilff_pkg::cmd_t cmd,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output ilff_pkg::rsp_t      rsp
);
	import ilff_pkg::*;

	localparam int UNITS    = HEAP_BYTES / ALIGN_BYTES;
	localparam int IDX_W    = $clog2(UNITS);
	localparam int SIZE_W   = IDX_W + 1;
	localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
	localparam int OFF_W    = IDX_W + ALIGN_SH;
	localparam int CMP_W    = ((OFF_W + 1 > REQ_W + 1) ? OFF_W + 1 : REQ_W + 1) + 1;
	localparam int MW       = ((OFF_W > OFS_W) ? OFF_W : OFS_W) + 1;

	typedef struct packed {
		logic              used;
		logic [SIZE_W-1:0] units;
	} hdr_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_WALK,
		ST_SPLIT,
		ST_MERGE,
		ST_RESP
	} state_t;

	state_t            state_q;
	hdr_t              mem [UNITS];
	hdr_t              rd_data_q;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	hdr_t              wr_data;

	cmd_t              cmd_q;
	logic [IDX_W:0]    idx_q;
	logic [IDX_W-1:0]  prev_idx_q;
	logic [SIZE_W-1:0] prev_units_q;
	logic              prev_free_q;
	logic [SIZE_W-1:0] cur_units_q;
	logic              has_next_q;
	logic [IDX_W-1:0]  split_addr_q;
	logic [SIZE_W-1:0] split_units_q;
	logic [1:0]        status_q;
	logic [OFS_W-1:0]  grant_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [IDX_W:0]    nxt;
	logic [OFF_W-1:0]  hdr_off;
	logic [CMP_W-1:0]  blk_bytes;
	logic [CMP_W-1:0]  need_bytes;
	logic              fit;
	logic              split;
	logic [REQ_W:0]    req_p7;
	logic [SIZE_W-1:0] nb_units;
	logic              take;
	logic              match;
	logic              next_free;
	logic [SIZE_W-1:0] total;

	always_comb begin
		nxt        = idx_q + rd_data_q.units;
		hdr_off    = {idx_q[IDX_W-1:0], {ALIGN_SH{1'b0}}};
		blk_bytes  = CMP_W'({rd_data_q.units, {ALIGN_SH{1'b0}}});
		need_bytes = CMP_W'(cmd_q.request_bytes) + CMP_W'(HEADER_BYTES);
		fit        = (blk_bytes >= need_bytes) && (blk_bytes >= CMP_W'(ALIGN_BYTES));
		split      = blk_bytes >= (need_bytes + CMP_W'(ALIGN_BYTES));
		req_p7     = {1'b0, cmd_q.request_bytes} + (REQ_W + 1)'(7);
		nb_units   = SIZE_W'((req_p7 >> ALIGN_SH) + 1'b1);
		take       = !rd_data_q.used && fit;
		match      = (MW'(hdr_off) + MW'(HEADER_BYTES)) == MW'(cmd_q.user_offset);
		next_free  = has_next_q && !rd_data_q.used;
		total      = cur_units_q + (next_free ? rd_data_q.units : '0);
	end

	always_comb begin
		rd_addr = idx_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = '0;
		case (state_q)
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = '{used: 1'b0, units: SIZE_W'(UNITS)};
			end
			ST_IDLE: begin
				rd_addr = '0;
			end
			ST_WALK: begin
				rd_addr = nxt[IDX_W-1:0];
				if (cmd_q.op == OP_ALLOC && take) begin
					wr_en   = 1'b1;
					wr_data = '{used: 1'b1, units: (split ? nb_units : rd_data_q.units)};
				end
			end
			ST_SPLIT: begin
				wr_en   = 1'b1;
				wr_addr = split_addr_q;
				wr_data = '{used: 1'b0, units: split_units_q};
			end
			ST_MERGE: begin
				wr_en = 1'b1;
				if (prev_free_q) begin
					wr_addr = prev_idx_q;
					wr_data = '{used: 1'b0, units: prev_units_q + total};
				end else begin
					wr_data = '{used: 1'b0, units: total};
				end
			end
			default: begin
				rd_addr = idx_q[IDX_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q       <= cmd;
						idx_q       <= '0;
						prev_free_q <= 1'b0;
						state_q     <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (cmd_q.op == OP_ALLOC) begin
						if (take) begin
							status_q <= STATUS_OK;
							grant_q  <= OFS_W'(hdr_off + OFF_W'(HEADER_BYTES));
							if (split) begin
								split_addr_q  <= IDX_W'(idx_q + nb_units);
								split_units_q <= rd_data_q.units - nb_units;
								state_q       <= ST_SPLIT;
							end else begin
								state_q <= ST_RESP;
							end
						end else if (nxt == SIZE_W'(UNITS)) begin
							status_q <= STATUS_NOFIT;
							grant_q  <= '0;
							state_q  <= ST_RESP;
						end else begin
							idx_q <= nxt;
						end
					end else begin
						if (match) begin
							cur_units_q <= rd_data_q.units;
							has_next_q  <= nxt != SIZE_W'(UNITS);
							status_q    <= STATUS_OK;
							grant_q     <= '0;
							state_q     <= ST_MERGE;
						end else if (nxt == SIZE_W'(UNITS)) begin
							status_q <= STATUS_BADPTR;
							grant_q  <= '0;
							state_q  <= ST_RESP;
						end else begin
							prev_idx_q   <= idx_q[IDX_W-1:0];
							prev_units_q <= rd_data_q.units;
							prev_free_q  <= !rd_data_q.used;
							idx_q        <= nxt;
						end
					end
				end
				ST_SPLIT: begin
					state_q <= ST_RESP;
				end
				ST_MERGE: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q   <= '{status: status_q, granted_offset: grant_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ilff_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilff_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 cmd_valid,
	input wire                 cmd_stall,
	input wire ilff_pkg::cmd_t cmd,
	input wire                 rsp_valid,
	input wire                 rsp_stall,
	input wire ilff_pkg::rsp_t rsp
);
	import ilff_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while previous one in progress");

	a_fail_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STATUS_OK |-> rsp.granted_offset == '0)
		else $error("failed response carries an offset");

	a_grant_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_OK && rsp.granted_offset != '0
		|-> rsp.granted_offset[3:0] == 4'd8)
		else $error("granted offset not on a block boundary");

endmodule

bind implicit_list_first_fit_allocator ilff_checker u_ilff_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import ilff_pkg::*;

	localparam int MAX_BLOCKS   = HEAP_BYTES / ALIGN_BYTES + 1;
	localparam int RANDOM_ITEMS = 800;
	localparam int DRAIN_CYCLES = 600;
	localparam int IDLE_PCT     = 23;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	cmd_t queued_cmds[$];
	rsp_t expected_replies[$];

	int blk_size[MAX_BLOCKS];
	bit blk_used[MAX_BLOCKS];
	int blk_count;

	bit cmd_done = 1'b0;
	bit quiet    = 1'b0;

	int mismatch_count = 0;
	int grants         = 0;
	int no_fits        = 0;
	int releases       = 0;
	int bad_ptrs       = 0;
	int peak_blocks    = 1;

	implicit_list_first_fit_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	task automatic coalesce_heap();
		int w;
		w = 0;
		for (int r = 0; r < blk_count; r++) begin
			if (w > 0 && !blk_used[w-1] && !blk_used[r]) begin
				blk_size[w-1] += blk_size[r];
			end else begin
				blk_size[w] = blk_size[r];
				blk_used[w] = blk_used[r];
				w++;
			end
		end
		blk_count = w;
	endtask

	task automatic predict_reply(input cmd_t c, output rsp_t r);
		int off;
		int sz;
		int nb;
		int req;
		bit found;
		r     = '0;
		off   = 0;
		found = 1'b0;
		req   = c.request_bytes;
		if (c.op == OP_ALLOC) begin
			r.status = STATUS_NOFIT;
			for (int i = 0; i < blk_count && !found; i++) begin
				sz = blk_size[i];
				if (!blk_used[i] && sz >= req + HEADER_BYTES && sz >= ALIGN_BYTES) begin
					if (sz - HEADER_BYTES - req >= ALIGN_BYTES && blk_count < MAX_BLOCKS) begin
						nb = ((req + 7) / ALIGN_BYTES + 1) * ALIGN_BYTES;
						for (int j = blk_count; j > i + 1; j--) begin
							blk_size[j] = blk_size[j-1];
							blk_used[j] = blk_used[j-1];
						end
						blk_size[i+1] = sz - nb;
						blk_used[i+1] = 1'b0;
						blk_size[i]   = nb;
						blk_count++;
					end
					blk_used[i]      = 1'b1;
					r.status         = STATUS_OK;
					r.granted_offset = OFS_W'(off + HEADER_BYTES);
					found            = 1'b1;
				end else begin
					off += sz;
				end
			end
		end else begin
			r.status = STATUS_BADPTR;
			for (int i = 0; i < blk_count && !found; i++) begin
				if (off + HEADER_BYTES == int'(c.user_offset)) begin
					blk_used[i] = 1'b0;
					coalesce_heap();
					r.status = STATUS_OK;
					found    = 1'b1;
				end else begin
					off += blk_size[i];
				end
			end
		end
	endtask

	function automatic cmd_t make_cmd(input logic op, input int value);
		cmd_t c;
		c.op            = op;
		c.request_bytes = REQ_W'($urandom);
		c.user_offset   = OFS_W'($urandom);
		if (op == OP_ALLOC)
			c.request_bytes = REQ_W'(value);
		else
			c.user_offset = OFS_W'(value);
		return c;
	endfunction

	function automatic int pick_block_offset(input bit want_used);
		int offs[$];
		int off;
		off = 0;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_used[i] == want_used)
				offs.push_back(off + HEADER_BYTES);
			off += blk_size[i];
		end
		if (offs.size() == 0)
			return -1;
		return offs[$urandom_range(offs.size() - 1)];
	endfunction

	always @(negedge clk) begin : drive_cmd
		logic nxt_valid;
		cmd_t nxt_cmd;
		nxt_valid = cmd_valid;
		nxt_cmd   = cmd;
		// advance only once the current transfer is taken
		if (arst_n && (!cmd_valid || cmd_done)) begin
			nxt_valid = 1'b0;
			if (queued_cmds.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				nxt_cmd   = queued_cmds.pop_front();
				nxt_valid = 1'b1;
			end
		end
		cmd_done = 1'b0;
		cmd_valid <= nxt_valid;
		cmd       <= nxt_cmd;
		rsp_stall <= arst_n && !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin : check_replies
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_replies.size() == 0) begin
					report_mismatch($sformatf("reply with nothing outstanding (status %0d offset %0d)",
						rsp.status, rsp.granted_offset));
				end else begin
					want = expected_replies.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status got %0d, expected %0d",
							rsp.status, want.status));
					if (rsp.granted_offset !== want.granted_offset)
						report_mismatch($sformatf("granted_offset got %0d, expected %0d",
							rsp.granted_offset, want.granted_offset));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				predict_reply(cmd, want);
				expected_replies.push_back(want);
				cmd_done = 1'b1;
				if (want.status == STATUS_NOFIT)
					no_fits++;
				else if (want.status == STATUS_BADPTR)
					bad_ptrs++;
				else if (cmd.op == OP_ALLOC)
					grants++;
				else
					releases++;
				if (blk_count > peak_blocks)
					peak_blocks = blk_count;
			end
		end
	end

	initial begin : stimulus
		cmd_t c;
		int roll;
		int req;
		int ofs;
		int alloc_pct;
		blk_size[0] = HEAP_BYTES;
		blk_used[0] = 1'b0;
		blk_count   = 1;

		queued_cmds.push_back(make_cmd(OP_ALLOC, 0));
		queued_cmds.push_back(make_cmd(OP_ALLOC, 1));
		queued_cmds.push_back(make_cmd(OP_ALLOC, 9));
		queued_cmds.push_back(make_cmd(OP_ALLOC, 8191));
		queued_cmds.push_back(make_cmd(OP_ALLOC, HEAP_BYTES));
		queued_cmds.push_back(make_cmd(OP_FREE, 4095));
		queued_cmds.push_back(make_cmd(OP_FREE, 0));
		queued_cmds.push_back(make_cmd(OP_FREE, 24));
		queued_cmds.push_back(make_cmd(OP_FREE, 24));
		queued_cmds.push_back(make_cmd(OP_ALLOC, 8));
		queued_cmds.push_back(make_cmd(OP_FREE, 8));
		queued_cmds.push_back(make_cmd(OP_FREE, 24));
		queued_cmds.push_back(make_cmd(OP_FREE, 40));
		queued_cmds.push_back(make_cmd(OP_ALLOC, HEAP_BYTES - HEADER_BYTES));
		queued_cmds.push_back(make_cmd(OP_ALLOC, 0));
		queued_cmds.push_back(make_cmd(OP_FREE, 8));
		queued_cmds.push_back(make_cmd(OP_ALLOC, HEAP_BYTES - 24));
		queued_cmds.push_back(make_cmd(OP_ALLOC, 8));
		queued_cmds.push_back(make_cmd(OP_FREE, HEAP_BYTES - HEADER_BYTES));
		queued_cmds.push_back(make_cmd(OP_FREE, HEAP_BYTES - ALIGN_BYTES));
		queued_cmds.push_back(make_cmd(OP_FREE, 8));
		queued_cmds.push_back(make_cmd(OP_ALLOC, HEAP_BYTES - 7));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			while (queued_cmds.size() >= 2)
				@(posedge clk);
			// hold the sender until the block has fully drained
			if (n % 200 == 100) begin
				while (queued_cmds.size() != 0 || cmd_valid || expected_replies.size() != 0)
					@(posedge clk);
			end
			quiet = (n >= 300 && n < 450);
			if (n >= 500 && n < 650)
				alloc_pct = 85;
			else
				alloc_pct = (blk_count < 64) ? 60 : 40;

			roll = $urandom_range(99);
			if (roll < 6) begin
				c = make_cmd(OP_ALLOC, $urandom_range(8191));
			end else if (roll < 12) begin
				c = make_cmd(OP_FREE, $urandom_range(4095));
			end else if (roll < 16) begin
				ofs = pick_block_offset(1'b0);
				c = make_cmd(OP_FREE, (ofs < 0) ? $urandom_range(4095) : ofs);
			end else if ($urandom_range(99) < alloc_pct) begin
				req = ($urandom_range(9) == 0) ? $urandom_range(1024) : $urandom_range(96);
				c = make_cmd(OP_ALLOC, req);
			end else begin
				ofs = pick_block_offset(1'b1);
				if (ofs < 0)
					c = make_cmd(OP_ALLOC, $urandom_range(64));
				else
					c = make_cmd(OP_FREE, ofs);
			end
			queued_cmds.push_back(c);
		end

		while (queued_cmds.size() != 0 || cmd_valid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d grants, %0d no-fit allocates, %0d releases, %0d bad pointers.",
			grants, no_fits, releases, bad_ptrs);
		$display("Block list peaked at %0d blocks; %0d mismatches.", peak_blocks,
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Run exceeded its time limit.");
		$display("CHECK FAILED");
		$finish;
	end

endmodule
